### design/assert_macros.svh
// Assertion macros used by palette_nearest_color_search.
// Depends on nothing; each file that asserts includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

### design/pncs_pkg.sv
// Types and constants of the palette nearest-colour search.
// Depends on nothing; used by palette_nearest_color_search.
package pncs_pkg;

    // Item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Widths of the register, components and distance
    localparam int COUNT_W = 9;
    localparam int COMP_W  = 8;
    localparam int INDEX_W = 8;
    localparam int SQ_W    = 2 * COMP_W;
    localparam int DIST_W  = SQ_W + 2;

    // Largest entry count the 8-bit result can reach
    localparam int SEARCH_LIMIT = 256;

    // Worst distance, the start value of the running minimum
    localparam logic [DIST_W-1:0] DIST_MAX = ~'0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } state_t;

endpackage

### design/palette_nearest_color_search.sv
// Nearest palette colour search: a palette write or a query is taken only in idle. A write
// item gives no result. A query sweeps the first N entries, N being color_count saturated
// to the palette depth and to 256, one squared-distance evaluation per cycle through the
// single read port of the palette memory. After the last read the block drains the read,
// square and sum stages, detects the end of the sweep and loads the result register. An
// exact match stops the sweep sooner. While a previous result waits to be taken, the block
// holds in the done state. The block is back in idle at the edge that loads the result, so
// the next item can be taken in the following cycle. The result register lets the next
// item enter while a result is still waiting to be taken.
// Depends on pncs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module palette_nearest_color_search #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_data,
    // Input item channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [7:0] s_entry_index,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    // Result item channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_match_index
);

    localparam int AW     = (PALETTE_DEPTH > 2) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int WIW    = (AW > pncs_pkg::INDEX_W) ? AW : pncs_pkg::INDEX_W;
    localparam int CIW    = (AW > pncs_pkg::COUNT_W) ? AW : pncs_pkg::COUNT_W;
    localparam int LIMIT  = (PALETTE_DEPTH < pncs_pkg::SEARCH_LIMIT) ?
                            PALETTE_DEPTH : pncs_pkg::SEARCH_LIMIT;
    localparam logic [pncs_pkg::COUNT_W-1:0] LIMIT_W = pncs_pkg::COUNT_W'(LIMIT);
    localparam logic [12:0] DEPTH_W = 13'(PALETTE_DEPTH);
    localparam int ENTRY_W = 3 * pncs_pkg::COMP_W;

    // Palette memory
    logic [ENTRY_W-1:0] palette_mem [PALETTE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // Control and datapath registers
    pncs_pkg::state_t state_reg, state_next;
    logic [pncs_pkg::COUNT_W-1:0] color_count_reg;
    logic [pncs_pkg::COUNT_W-1:0] bound_reg, bound_next;
    logic [pncs_pkg::COUNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic [pncs_pkg::COMP_W-1:0]  q_red_reg, q_green_reg, q_blue_reg;
    logic                         v1_reg, v1_next;
    logic                         v2_reg, v2_next;
    logic [pncs_pkg::INDEX_W-1:0] idx1_reg, idx2_reg;
    logic [pncs_pkg::SQ_W-1:0]    sq_r_reg, sq_g_reg, sq_b_reg;
    logic [pncs_pkg::DIST_W-1:0]  best_reg, best_next;
    logic [pncs_pkg::INDEX_W-1:0] found_reg, found_next;
    logic                         m_valid_reg, m_valid_next;
    logic [pncs_pkg::INDEX_W-1:0] m_match_index_reg;

    // Decoded control
    logic                         s_accept, query_start, write_en;
    logic                         in_sweep, in_done, out_free, issue_en;
    logic                         sweep_end, exact_hit, dist_less;
    logic [WIW-1:0]               wr_index_ext;
    logic [CIW-1:0]               rd_index_ext;
    logic [AW-1:0]                wr_addr, rd_addr;
    logic [pncs_pkg::COMP_W-1:0]  mem_r, mem_g, mem_b;
    logic [pncs_pkg::COMP_W-1:0]  d_r, d_g, d_b;
    logic [pncs_pkg::DIST_W-1:0]  dist_sum;

    function automatic logic [pncs_pkg::COMP_W-1:0] abs_diff(
        input logic [pncs_pkg::COMP_W-1:0] a,
        input logic [pncs_pkg::COMP_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Handshakes and address forms
    assign s_accept     = s_valid && s_ready;
    assign query_start  = s_accept && (s_func == pncs_pkg::FUNC_QUERY);
    assign wr_index_ext = WIW'(s_entry_index);
    assign wr_addr      = wr_index_ext[AW-1:0];
    assign write_en     = s_accept && (s_func == pncs_pkg::FUNC_WRITE) &&
                          (13'(s_entry_index) < DEPTH_W);
    assign rd_index_ext = CIW'(issue_cnt_reg);
    assign rd_addr      = rd_index_ext[AW-1:0];
    assign out_free     = !m_valid_reg || m_ready;
    assign cfg_ready    = 1'b1;

    // Distance unit: absolute differences, then the sum of squares
    assign mem_r     = rd_data_reg[ENTRY_W-1 -: pncs_pkg::COMP_W];
    assign mem_g     = rd_data_reg[pncs_pkg::SQ_W-1 -: pncs_pkg::COMP_W];
    assign mem_b     = rd_data_reg[pncs_pkg::COMP_W-1:0];
    assign d_r       = abs_diff(mem_r, q_red_reg);
    assign d_g       = abs_diff(mem_g, q_green_reg);
    assign d_b       = abs_diff(mem_b, q_blue_reg);
    assign dist_sum  = pncs_pkg::DIST_W'(sq_r_reg) + pncs_pkg::DIST_W'(sq_g_reg) +
                       pncs_pkg::DIST_W'(sq_b_reg);
    assign dist_less = v2_reg && (dist_sum < best_reg);
    assign exact_hit = in_sweep && v2_reg && (dist_sum == '0);
    assign sweep_end = exact_hit ||
                       (in_sweep && (issue_cnt_reg == bound_reg) && !v1_reg && !v2_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pncs_pkg::ST_IDLE: begin
                if (query_start) begin
                    state_next = pncs_pkg::ST_SWEEP;
                end
            end
            pncs_pkg::ST_SWEEP: begin
                if (sweep_end) begin
                    state_next = pncs_pkg::ST_DONE;
                end
            end
            pncs_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = pncs_pkg::ST_IDLE;
                end
            end
            default: state_next = pncs_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_ready  = 1'b0;
        in_sweep = 1'b0;
        in_done  = 1'b0;
        case (state_reg)
            pncs_pkg::ST_IDLE:  s_ready  = 1'b1;
            pncs_pkg::ST_SWEEP: in_sweep = 1'b1;
            pncs_pkg::ST_DONE:  in_done  = 1'b1;
            default: s_ready = 1'b0;
        endcase
    end

    assign issue_en = in_sweep && (issue_cnt_reg < bound_reg) && !exact_hit;

    // Sequencer counters, running minimum and result register
    always_comb begin
        bound_next     = bound_reg;
        issue_cnt_next = issue_cnt_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        v1_next        = issue_en;
        v2_next        = in_sweep && v1_reg && !exact_hit;
        m_valid_next   = m_valid_reg && !m_ready;
        if (query_start) begin
            bound_next     = (color_count_reg > LIMIT_W) ? LIMIT_W : color_count_reg;
            issue_cnt_next = '0;
            best_next      = pncs_pkg::DIST_MAX;
            found_next     = '0;
        end
        if (issue_en) begin
            issue_cnt_next = issue_cnt_reg + 1'b1;
        end
        // Keep the earliest entry on equal distances
        if (in_sweep && dist_less) begin
            best_next  = dist_sum;
            found_next = idx2_reg;
        end
        if (in_done && out_free) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= pncs_pkg::ST_IDLE;
            color_count_reg <= '0;
            bound_reg       <= '0;
            issue_cnt_reg   <= '0;
            best_reg        <= pncs_pkg::DIST_MAX;
            found_reg       <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bound_reg     <= bound_next;
            issue_cnt_reg <= issue_cnt_next;
            best_reg      <= best_next;
            found_reg     <= found_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                color_count_reg <= cfg_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (query_start) begin
            q_red_reg   <= s_red;
            q_green_reg <= s_green;
            q_blue_reg  <= s_blue;
        end
        if (issue_en) begin
            idx1_reg <= issue_cnt_reg[pncs_pkg::INDEX_W-1:0];
        end
        if (v1_reg) begin
            idx2_reg <= idx1_reg;
            sq_r_reg <= pncs_pkg::SQ_W'(d_r) * pncs_pkg::SQ_W'(d_r);
            sq_g_reg <= pncs_pkg::SQ_W'(d_g) * pncs_pkg::SQ_W'(d_g);
            sq_b_reg <= pncs_pkg::SQ_W'(d_b) * pncs_pkg::SQ_W'(d_b);
        end
        if (in_done && out_free) begin
            m_match_index_reg <= found_reg;
        end
    end

    // Palette memory: write on write items, registered read during the sweep
    always_ff @(posedge aclk) begin
        if (write_en) begin
            palette_mem[wr_addr] <= {s_red, s_green, s_blue};
        end
        if (issue_en) begin
            rd_data_reg <= palette_mem[rd_addr];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_match_index = m_match_index_reg;

    // Checks
    `ASSERT_CLK(a_idle_pipe_empty, s_ready |-> (!v1_reg && !v2_reg), "pipeline busy in idle")
    `ASSERT_NEVER(a_issue_in_bound, issue_cnt_reg > bound_reg, "issue count beyond bound")
    `ASSERT_CLK(a_query_busy, query_start |=> !s_ready, "ready after query start")
    `ASSERT_CLK(a_exact_stops, exact_hit |=> (state_reg == pncs_pkg::ST_DONE), "exact hit kept sweeping")

endmodule
